// File: hw/rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared constants and types of the LRU key-value cache
// Sizes of the entry store, field widths and the control bundle that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 5;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W   = IDX_W;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Register map: byte address bit 2 selects the register index.
    localparam logic REG_ACTIVE_ENTRIES = 1'b0;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    // Request codes.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture an accepted request
        logic lookup;   // compare keys and find the oldest entry
        logic commit;   // update the store and load the result register
    } cmd_t;

endpackage

// File: hw/rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer of the LRU key-value cache
// Steps one request through capture, lookup and update, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module lkvc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output lkvc_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The result register may be loaded once the previous result is gone.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/lkvc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_dp: entry store and result datapath of the LRU key-value cache
// Holds keys, values, valid bits and recency ranks, matches keys in
// parallel and applies the replacement update.
// ----------------------------------------------------------------------------
module lkvc_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lkvc_pkg::cmd_t                  cmd,
    input  logic [lkvc_pkg::CFG_W-1:0]      active_entries,
    input  logic                            action,
    input  logic [lkvc_pkg::KEY_W-1:0]      key,
    input  logic [lkvc_pkg::VAL_W-1:0]      value,
    output logic                            hit,
    output logic [lkvc_pkg::VAL_W-1:0]      read_value,
    output logic                            evicted,
    output logic [lkvc_pkg::KEY_W-1:0]      evicted_key
);

    localparam int N = lkvc_pkg::ENTRIES;

    // Entry store.
    logic [lkvc_pkg::KEY_W-1:0]   key_reg   [N];
    logic [lkvc_pkg::VAL_W-1:0]   value_reg [N];
    logic [N-1:0]                 valid_reg;
    logic [N-1:0]                 valid_next;
    logic [lkvc_pkg::RANK_W-1:0]  rank_reg  [N];
    logic [lkvc_pkg::RANK_W-1:0]  rank_next [N];
    logic [lkvc_pkg::CNT_W-1:0]   fill_reg;
    logic [lkvc_pkg::CNT_W-1:0]   fill_next;

    // Captured request and lookup results.
    logic                         req_action_reg;
    logic [lkvc_pkg::KEY_W-1:0]   req_key_reg;
    logic [lkvc_pkg::VAL_W-1:0]   req_value_reg;
    logic                         hit_reg;
    logic [lkvc_pkg::IDX_W-1:0]   hit_idx_reg;
    logic [lkvc_pkg::IDX_W-1:0]   old_idx_reg;

    // Result register.
    logic                         res_hit_reg;
    logic [lkvc_pkg::VAL_W-1:0]   res_value_reg;
    logic                         res_evicted_reg;
    logic [lkvc_pkg::KEY_W-1:0]   res_evkey_reg;

    logic [N-1:0]                 match;
    logic [N-1:0]                 oldest;
    logic [lkvc_pkg::IDX_W-1:0]   match_idx;
    logic [lkvc_pkg::IDX_W-1:0]   oldest_idx;
    logic [lkvc_pkg::RANK_W-1:0]  top_rank;
    logic [lkvc_pkg::CMP_W-1:0]   cap;
    logic [lkvc_pkg::CMP_W-1:0]   fill_ext;
    logic                         is_put;
    logic                         do_evict;
    logic                         do_fill;
    logic [lkvc_pkg::IDX_W-1:0]   slot;
    logic [lkvc_pkg::RANK_W-1:0]  slot_rank;

    // Lookup: parallel key compare, and the least recent valid entry is the
    // one holding the highest rank, fill_count - 1.
    assign top_rank = lkvc_pkg::RANK_W'(fill_reg - lkvc_pkg::CNT_W'(1));

    always_comb
    begin
        match_idx  = '0;
        oldest_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == req_key_reg);
            oldest[i] = valid_reg[i] && (rank_reg[i] == top_rank);
            if (match[i])
            begin
                match_idx = match_idx | lkvc_pkg::IDX_W'(i);
            end
            if (oldest[i])
            begin
                oldest_idx = oldest_idx | lkvc_pkg::IDX_W'(i);
            end
        end
    end

    // Effective capacity: zero acts as one, anything above the store size
    // acts as the store size.
    always_comb
    begin
        priority if (active_entries == '0)
        begin
            cap = lkvc_pkg::CMP_W'(1);
        end
        else if (lkvc_pkg::CMP_W'(active_entries) > lkvc_pkg::CMP_W'(N))
        begin
            cap = lkvc_pkg::CMP_W'(N);
        end
        else
        begin
            cap = lkvc_pkg::CMP_W'(active_entries);
        end
    end

    assign fill_ext = lkvc_pkg::CMP_W'(fill_reg);
    assign is_put   = (req_action_reg == lkvc_pkg::ACT_PUT);
    assign do_evict = is_put && !hit_reg && (fill_ext >= cap);
    assign do_fill  = is_put && !hit_reg && !(fill_ext >= cap);

    always_comb
    begin
        priority if (hit_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (do_evict)
        begin
            slot = old_idx_reg;
        end
        else
        begin
            slot = fill_reg[lkvc_pkg::IDX_W-1:0];
        end
    end

    assign slot_rank = rank_reg[slot];

    // Recency update: entries more recent than the touched one age by one;
    // a newly filled entry ages every valid entry.
    always_comb
    begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (hit_reg || is_put)
        begin
            for (int i = 0; i < N; i++)
            begin
                if ((lkvc_pkg::IDX_W'(i) != slot) && valid_reg[i]
                    && (do_fill || (rank_reg[i] < slot_rank)))
                begin
                    rank_next[i] = rank_reg[i] + lkvc_pkg::RANK_W'(1);
                end
            end
            rank_next[slot] = '0;
        end
        if (do_fill)
        begin
            valid_next[slot] = 1'b1;
            fill_next        = fill_reg + lkvc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_action_reg <= action;
            req_key_reg    <= key;
            req_value_reg  <= value;
        end
        if (cmd.lookup)
        begin
            hit_reg     <= |match;
            hit_idx_reg <= match_idx;
            old_idx_reg <= oldest_idx;
        end
        if (cmd.commit)
        begin
            if (is_put)
            begin
                key_reg[slot]   <= req_key_reg;
                value_reg[slot] <= req_value_reg;
            end
            res_hit_reg     <= hit_reg;
            res_value_reg   <= (!is_put && hit_reg) ? value_reg[hit_idx_reg] : '0;
            res_evicted_reg <= do_evict;
            res_evkey_reg   <= do_evict ? key_reg[old_idx_reg] : '0;
        end
    end

    assign hit         = res_hit_reg;
    assign read_value  = res_value_reg;
    assign evicted     = res_evicted_reg;
    assign evicted_key = res_evkey_reg;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Output: out_valid rises when the update step loads the result register;
// that step waits while an earlier result is still held by out_stall.
// Requests: none is taken until the last one is updated (capture, lookup,
// update): the controller steps one request at a time through the store.
// Reset: asynchronous, active low; empties the store, clears ranks and the
// fill count and sets active_entries to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache
(
    input  logic                            clk,
    input  logic                            rst_n,

    // APB-style configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lkvc_pkg::ADDR_W-1:0]     paddr,
    input  logic [lkvc_pkg::DATA_W-1:0]     pwdata,
    output logic [lkvc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,

    // Request channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [lkvc_pkg::KEY_W-1:0]      key,
    input  logic [lkvc_pkg::VAL_W-1:0]      value,

    // Result channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [lkvc_pkg::VAL_W-1:0]      read_value,
    output logic                            evicted,
    output logic [lkvc_pkg::KEY_W-1:0]      evicted_key
);

    // The single configuration register. The user must write it only while the
    // cache is idle (the block itself does not enforce this), so the datapath may read it directly.
    logic [lkvc_pkg::CFG_W-1:0] active_reg;
    logic                       reg_sel;
    logic                       wr_en;

    lkvc_pkg::cmd_t cmd;

    // Bit 2 of the byte address picks the register; only index zero exists,
    // so writes elsewhere are dropped and read back as zero.
    assign reg_sel = (paddr[2] == lkvc_pkg::REG_ACTIVE_ENTRIES);
    assign wr_en   = psel && penable && pwrite && reg_sel;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? lkvc_pkg::DATA_W'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= lkvc_pkg::ACTIVE_RESET;
        end
        else if (wr_en)
        begin
            active_reg <= pwdata[lkvc_pkg::CFG_W-1:0];
        end
    end

    // The controller steps each request through capture, lookup and
    // update, and holds the update back while a finished result still
    // waits on a stalled output.
    lkvc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath holds the entries, matches keys across all of them in
    // parallel and keeps the result register that drives the output fields.
    lkvc_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .active_entries (active_reg),
        .action         (action),
        .key            (key),
        .value          (value),
        .hit            (hit),
        .read_value     (read_value),
        .evicted        (evicted),
        .evicted_key    (evicted_key)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU key-value cache
// Gets and puts are sent through the request channel while a cycle-free
// model of the cache predicts each result. The model tracks keys, values,
// recency ranks and the fill count. Results are compared field by field in
// order. The capacity register is rewritten between phases, including the
// zero and oversize settings and a lowering after the store has filled.
// ----------------------------------------------------------------------------

typedef struct {
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] read_value;
    logic                       evicted;
    logic [lkvc_pkg::KEY_W-1:0] evicted_key;
} lookup_outcome_t;

class cache_mirror;
    logic [lkvc_pkg::KEY_W-1:0]  slot_key [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0]  slot_value [lkvc_pkg::ENTRIES];
    bit                          slot_used [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::RANK_W-1:0] slot_rank [lkvc_pkg::ENTRIES];
    int unsigned                 used_count;
    logic [lkvc_pkg::CFG_W-1:0]  active_entries;
    lookup_outcome_t             awaited_outcomes [$];
    int errors, checked, gets, puts, hits, evictions;

    function new();
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_rank[i] = '0;
        end
        used_count = 0;
        active_entries = lkvc_pkg::ACTIVE_RESET;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 30)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function int outstanding();
        return awaited_outcomes.size();
    endfunction

    function void set_active(logic [lkvc_pkg::CFG_W-1:0] v);
        active_entries = v;
    endfunction

    // Zero behaves as one; anything above the store size is clipped to it.
    function int unsigned capacity();
        int unsigned c;
        c = active_entries;
        if (c == 0)
            c = 1;
        if (c > lkvc_pkg::ENTRIES)
            c = lkvc_pkg::ENTRIES;
        return c;
    endfunction

    // Slot s becomes most recent; valid slots newer than old_rank age by one.
    function void promote(int s, int old_rank);
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (i != s && slot_used[i] && int'(slot_rank[i]) < old_rank)
                slot_rank[i] = slot_rank[i] + 1'b1;
        slot_rank[s] = '0;
    endfunction

    function int find_slot(logic [lkvc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function int oldest_slot();
        int best;
        bit found;
        best = 0;
        found = 1'b0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (slot_used[i] && (!found || slot_rank[i] > slot_rank[best]))
            begin
                best = i;
                found = 1'b1;
            end
        return best;
    endfunction

    function void note_request(logic act, logic [lkvc_pkg::KEY_W-1:0] k,
                               logic [lkvc_pkg::VAL_W-1:0] v);
        lookup_outcome_t o;
        int s;
        o = '{1'b0, '0, 1'b0, '0};
        s = find_slot(k);
        if (act == lkvc_pkg::ACT_GET)
        begin
            gets++;
            if (s >= 0)
            begin
                o.hit = 1'b1;
                o.read_value = slot_value[s];
                promote(s, slot_rank[s]);
            end
        end
        else
        begin
            puts++;
            if (s >= 0)
            begin
                o.hit = 1'b1;
                slot_value[s] = v;
                promote(s, slot_rank[s]);
            end
            else
            begin
                if (used_count >= capacity() && used_count > 0)
                begin
                    s = oldest_slot();
                    o.evicted = 1'b1;
                    o.evicted_key = slot_key[s];
                    promote(s, slot_rank[s]);
                    evictions++;
                end
                else
                begin
                    s = used_count % lkvc_pkg::ENTRIES;
                    used_count++;
                    slot_used[s] = 1'b1;
                    promote(s, lkvc_pkg::ENTRIES + 1);
                end
                slot_key[s] = k;
                slot_value[s] = v;
            end
        end
        if (o.hit)
            hits++;
        awaited_outcomes.push_back(o);
    endfunction

    function void check_result(logic h, logic [lkvc_pkg::VAL_W-1:0] rv, logic ev,
                               logic [lkvc_pkg::KEY_W-1:0] ek);
        lookup_outcome_t o;
        if (awaited_outcomes.size() == 0)
        begin
            report("result arrived with no request outstanding");
            return;
        end
        o = awaited_outcomes.pop_front();
        checked++;
        if (h !== o.hit)
            report($sformatf("result %0d hit %b, want %b", checked, h, o.hit));
        if (rv !== o.read_value)
            report($sformatf("result %0d read_value %h, want %h", checked, rv,
                             o.read_value));
        if (ev !== o.evicted)
            report($sformatf("result %0d evicted %b, want %b", checked, ev, o.evicted));
        if (ek !== o.evicted_key)
            report($sformatf("result %0d evicted_key %h, want %h", checked, ek,
                             o.evicted_key));
    endfunction
endclass

module testbench;

    // RESULT_LATENCY sets the extra settle time of the drain waits; the block
    // takes a new request only after the update of the last one is done, and the
    // drain waits use this to let the pipe settle.
    localparam int RESULT_LATENCY   = 2;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int POOL_SIZE        = 24;
    localparam logic [lkvc_pkg::ADDR_W-1:0] ACTIVE_ADDR =
        {lkvc_pkg::REG_ACTIVE_ENTRIES, 2'b00};

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lkvc_pkg::ADDR_W-1:0] paddr;
    logic [lkvc_pkg::DATA_W-1:0] pwdata;
    logic [lkvc_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_stall;
    logic                        action;
    logic [lkvc_pkg::KEY_W-1:0]  key;
    logic [lkvc_pkg::VAL_W-1:0]  value;
    logic                        out_valid;
    logic                        out_stall;
    logic                        hit;
    logic [lkvc_pkg::VAL_W-1:0]  read_value;
    logic                        evicted;
    logic [lkvc_pkg::KEY_W-1:0]  evicted_key;

    cache_mirror mirror = new();

    // Idling is switched off for the final phase so the block also sees a
    // back-to-back stream with an always-ready receiver.
    bit idling_on;
    int stall_left;
    int settings_used;
    int drain_pauses;
    logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    lru_key_value_cache uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Generous fixed limit: a slow correct run needs well under 100 us.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver side: stall bursts start at random, so the result register
    // is held at every phase of the three-step sequence.
    always @(posedge clk)
    begin
        if (!rst_n || !idling_on)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Every accepted result is checked against the oldest predicted one.
    // Values are read just before the edge's updates take effect.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            mirror.check_result(hit, read_value, evicted, evicted_key);
    end

    // One request: an optional idle burst, then valid with a stable payload
    // until the block takes it. The model is updated at acceptance.
    task automatic send_request(input logic act, input logic [lkvc_pkg::KEY_W-1:0] k,
                                input logic [lkvc_pkg::VAL_W-1:0] v);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        mirror.note_request(act, k, v);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.outstanding() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input bit is_write,
                                input logic [lkvc_pkg::DATA_W-1:0] wdata,
                                output logic [lkvc_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ACTIVE_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Capacity changes happen only with the block idle; the value is read
    // back to confirm the register took it.
    task automatic set_capacity(input logic [lkvc_pkg::CFG_W-1:0] cap);
        logic [lkvc_pkg::DATA_W-1:0] readback;
        apb_transfer(1'b1, lkvc_pkg::DATA_W'(cap), readback);
        mirror.set_active(cap);
        settings_used++;
        apb_transfer(1'b0, '0, readback);
        if (readback[lkvc_pkg::CFG_W-1:0] !== cap)
            mirror.report($sformatf("active_entries reads %h, want %h",
                                    readback[lkvc_pkg::CFG_W-1:0], cap));
    endtask

    // Random gets and puts. Most keys come from a small pool sized a little
    // above the live entry count, so hits, updates and evictions all occur;
    // the rest are fresh random keys. Halfway through, the sender waits for
    // the pipe to empty once.
    task automatic random_phase(input int count);
        int window;
        logic [lkvc_pkg::KEY_W-1:0] k;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                drain_results();
                drain_pauses++;
            end
            window = mirror.capacity();
            if (mirror.used_count > window)
                window = mirror.used_count;
            window = window + 4;
            if (window > POOL_SIZE)
                window = POOL_SIZE;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, window - 1)];
            else
                k = $urandom;
            send_request($urandom_range(0, 1) ? lkvc_pkg::ACT_PUT : lkvc_pkg::ACT_GET,
                         k, $urandom);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        action    = lkvc_pkg::ACT_GET;
        key       = '0;
        value     = '0;
        out_stall = 1'b0;
        idling_on = 1'b1;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A capacity of zero acts as one entry: every new key replaces the
        // single live one. Key and value extremes, a get on the empty store,
        // an update in place and a get carrying a value that must be ignored.
        set_capacity(lkvc_pkg::CFG_W'(0));
        send_request(lkvc_pkg::ACT_GET, '0, '0);
        send_request(lkvc_pkg::ACT_PUT, '0, '1);
        send_request(lkvc_pkg::ACT_GET, '0, '0);
        send_request(lkvc_pkg::ACT_PUT, '0, '0);
        send_request(lkvc_pkg::ACT_GET, '0, '1);
        send_request(lkvc_pkg::ACT_PUT, '1, 32'h1234_5678);
        send_request(lkvc_pkg::ACT_GET, '0, '0);
        send_request(lkvc_pkg::ACT_GET, '1, '1);
        send_request(lkvc_pkg::ACT_PUT, '1, '1);
        drain_results();

        // Three entries: fill, refresh two by gets, then force evictions
        // so the victim order follows recency rather than fill order.
        set_capacity(lkvc_pkg::CFG_W'(3));
        send_request(lkvc_pkg::ACT_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
        send_request(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h5A5A_5A5A);
        send_request(lkvc_pkg::ACT_GET, '1, '0);
        send_request(lkvc_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(lkvc_pkg::ACT_GET, 32'h0000_0001, '0);
        send_request(lkvc_pkg::ACT_GET, 32'h8000_0000, '0);
        send_request(lkvc_pkg::ACT_PUT, '1, 32'h8000_0000);
        send_request(lkvc_pkg::ACT_PUT, 32'h0000_0002, 32'hFFFF_FFFE);
        send_request(lkvc_pkg::ACT_GET, 32'h7FFF_FFFF, '0);
        drain_results();

        // Random phases: a capacity below the live count, an oversize value
        // that fills all sixteen entries, the nominal size, then a lowering
        // after the store is full.
        set_capacity(lkvc_pkg::CFG_W'(1));
        random_phase(RANDOM_PER_PHASE);
        set_capacity(lkvc_pkg::CFG_W'(31));
        random_phase(RANDOM_PER_PHASE);
        set_capacity(lkvc_pkg::CFG_W'(lkvc_pkg::ENTRIES));
        random_phase(RANDOM_PER_PHASE);
        set_capacity(lkvc_pkg::CFG_W'(4));
        random_phase(RANDOM_PER_PHASE);

        // Last phase: random capacity, no idling on either side.
        idling_on = 1'b0;
        set_capacity(lkvc_pkg::CFG_W'($urandom_range(0, 31)));
        random_phase(RANDOM_PER_PHASE);

        $display("Covered %0d requests (%0d gets, %0d puts) with %0d hits and %0d evictions.",
                 mirror.gets + mirror.puts, mirror.gets, mirror.puts, mirror.hits,
                 mirror.evictions);
        $display("Used %0d capacity settings, %0d mid-phase drains, %0d results checked.",
                 settings_used, drain_pauses, mirror.checked);
        if (mirror.errors == 0 && mirror.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
